// ----- sv/cbds_pkg.sv -----
package cbds_pkg;

    localparam int FracBits = 16;
    localparam int PtW = 32;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    typedef enum logic [CfgIdxW-1:0] {
        REG_COLOR_OFFSET = 3'd0,
        REG_REPEAT_SCALE = 3'd1,
        REG_BOX_SIZE = 3'd2,
        REG_MULT_SCALES = 3'd3,
        REG_MULT_WINDOWS = 3'd4,
        REG_MISC = 3'd5
    } cfg_reg_t;

    localparam int BitColorOff = 48;
    localparam int BitThreeAxes = 49;
    localparam int BitColorAdd = 50;
    localparam int BitPlane = 51;
    localparam int BitReplace = 52;
    localparam int BitDistReplace = 53;
    localparam int BitMultFirst = 54;

    typedef struct packed {
        logic signed [PtW-1:0] point_x;
        logic signed [PtW-1:0] point_y;
        logic signed [PtW-1:0] point_z;
        logic [7:0] iteration;
        logic signed [PtW-1:0] dist_in;
        logic signed [PtW-1:0] deriv_in;
        logic signed [PtW-1:0] color_in;
    } in_item_t;

    typedef struct packed {
        logic signed [PtW-1:0] new_x;
        logic signed [PtW-1:0] new_y;
        logic signed [PtW-1:0] new_z;
        logic signed [PtW-1:0] dist_out;
        logic signed [PtW-1:0] deriv_out;
        logic signed [PtW-1:0] color_out;
    } out_item_t;

    typedef struct packed {
        logic [CfgIdxW-1:0] index;
        logic [CfgDataW-1:0] data;
    } cfg_item_t;

    function automatic logic signed [PtW-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return hi[PtW-1:0];
        end
        if (v < lo) begin
            return lo[PtW-1:0];
        end
        return v[PtW-1:0];
    endfunction

    function automatic logic signed [63:0] widen(input logic [15:0] q);
        logic signed [63:0] s;
        s = 64'(signed'(q));
        return s <<< (FracBits - 8);
    endfunction

    function automatic logic in_window(input logic [7:0] it, input logic [15:0] w);
        return (it >= w[7:0]) && (it < w[15:8]);
    endfunction

endpackage

// ----- sv/cbds_if.sv -----
interface cbds_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/chessboard_box_distance_step_top.sv -----
// Box distance step with checker parity colouring, Q16.16.
// Channels: in_ch (sink) carries a point, iteration and running distance,
// derivative and colour; out_ch (source) carries the updated values;
// cfg_ch (sink) writes register index/data, always ready.
// An input transaction passes through stage 0, stage 1, the multiply stages
// and the output register before output valid. Throughput: one transaction
// per cycle while the receiver takes each output; the pipeline is fully
// registered with a valid bit per stage and advances whenever the last stage
// is empty or being taken. Five scale steps run in series, one per stage.
// When the receiver stalls, all stages hold and in_ch.ready drops while the
// last stage holds a transaction; nothing is lost or repeated.
// Reset clears all valid bits and loads register defaults.
// User must write configuration only while pipeline is empty; not enforced.
module chessboard_box_distance_step_top (
    input logic clk,
    input logic rst_n,
    cbds_if.sink in_ch,
    cbds_if.source out_ch,
    cbds_if.sink cfg_ch
);
    import cbds_pkg::*;

    localparam int NStg = 8;

    typedef struct packed {
        logic signed [PtW-1:0] p0;
        logic signed [PtW-1:0] p1;
        logic signed [PtW-1:0] p2;
        logic [7:0] it;
        logic signed [PtW-1:0] dst;
        logic signed [PtW-1:0] deriv;
        logic signed [PtW-1:0] color;
        logic signed [PtW-1:0] z0;
        logic signed [PtW-1:0] z1;
        logic signed [PtW-1:0] z2;
        logic [2:0] fl;
        logic signed [PtW-1:0] rde;
    } stg_t;

    logic [47:0] color_offset_reg;
    logic [47:0] repeat_scale_reg;
    logic [47:0] box_size_reg;
    logic [63:0] mult_scales_reg;
    logic [63:0] mult_windows_reg;
    logic [58:0] misc_reg;

    logic [NStg-1:0] vld_reg;
    stg_t stg_reg [NStg];
    stg_t stg_next [NStg];
    logic advance;

    assign cfg_ch.ready = 1'b1;
    assign advance = !vld_reg[NStg-1] || out_ch.ready;
    assign in_ch.ready = advance;
    assign out_ch.valid = vld_reg[NStg-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_offset_reg <= '0;
            repeat_scale_reg <= 48'd4398113620992;
            box_size_reg <= 48'd16777472;
            mult_scales_reg <= 64'd72058693566333184;
            mult_windows_reg <= '0;
            misc_reg <= 59'd256;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_reg_t'(cfg_ch.data.index))
                REG_COLOR_OFFSET: color_offset_reg <= cfg_ch.data.data[47:0];
                REG_REPEAT_SCALE: repeat_scale_reg <= cfg_ch.data.data[47:0];
                REG_BOX_SIZE: box_size_reg <= cfg_ch.data.data[47:0];
                REG_MULT_SCALES: mult_scales_reg <= cfg_ch.data.data;
                REG_MULT_WINDOWS: mult_windows_reg <= cfg_ch.data.data;
                REG_MISC: misc_reg <= cfg_ch.data.data[58:0];
                default: ;
            endcase
        end
    end

    // stage 0: checker products floored, box distance
    always_comb
    begin
        logic signed [63:0] col;
        logic signed [63:0] prod;
        logic signed [PtW-1:0] p [3];
        logic signed [PtW-1:0] z [3];
        logic [2:0] fl;
        stg_t s;
        p[0] = in_ch.data.point_x;
        p[1] = in_ch.data.point_y;
        p[2] = in_ch.data.point_z;
        for (int k = 0; k < 3; k++)
        begin
            col = 64'(p[k]) + widen(color_offset_reg[16*k +: 16]);
            prod = 64'(signed'(repeat_scale_reg[16*k +: 16])) * col;
            fl[k] = prod[8+FracBits];
            if (misc_reg[BitPlane])
            begin
                z[k] = p[k];
            end
            else
            begin
                z[k] = sat32((p[k] < 0 ? -64'(p[k]) : 64'(p[k]))
                    - widen(box_size_reg[16*k +: 16]));
            end
        end
        s.p0 = p[0];
        s.p1 = p[1];
        s.p2 = p[2];
        s.it = in_ch.data.iteration;
        s.dst = in_ch.data.dist_in;
        s.deriv = in_ch.data.deriv_in;
        s.color = in_ch.data.color_in;
        s.z0 = z[0];
        s.z1 = z[1];
        s.z2 = z[2];
        s.fl = fl;
        s.rde = '0;
        stg_next[0] = s;
    end

    // stage 1: colour, distance, replace
    always_comb
    begin
        stg_t s;
        logic par;
        logic signed [PtW-1:0] rde;
        logic signed [PtW-1:0] pv;
        s = stg_reg[0];
        par = s.fl[0] ^ s.fl[1] ^ (misc_reg[BitThreeAxes] & s.fl[2]);
        pv = par ? PtW'(64'sd1 <<< FracBits) : '0;
        if (!misc_reg[BitColorOff])
        begin
            if (misc_reg[BitColorAdd])
            begin
                s.color = sat32(64'(s.color) + 64'(pv));
            end
            else
            begin
                s.color = pv;
            end
        end
        if (misc_reg[BitPlane])
        begin
            rde = s.z2;
        end
        else
        begin
            rde = s.z0;
            if (s.z1 > rde) rde = s.z1;
            if (s.z2 > rde) rde = s.z2;
        end
        if (misc_reg[BitReplace] && in_window(s.it, misc_reg[47:32]))
        begin
            s.p0 = s.z0;
            s.p1 = s.z1;
            s.p2 = s.z2;
        end
        if (misc_reg[BitDistReplace] || rde < s.dst)
        begin
            s.dst = rde;
        end
        s.rde = rde;
        stg_next[1] = s;
    end

    // stages 2..6: one scale step each
    for (genvar m = 0; m < 5; m++)
    begin : g_mul
        always_comb
        begin
            stg_t s;
            logic [15:0] sc;
            logic [15:0] win;
            logic signed [63:0] scs;
            logic signed [63:0] sca;
            s = stg_reg[m+1];
            if (m < 4)
            begin
                sc = mult_scales_reg[16*m +: 16];
                win = mult_windows_reg[16*m +: 16];
            end
            else
            begin
                sc = misc_reg[15:0];
                win = misc_reg[31:16];
            end
            scs = 64'(signed'(sc));
            sca = scs < 0 ? -scs : scs;
            if (misc_reg[BitMultFirst+m] && in_window(s.it, win))
            begin
                s.p0 = sat32((64'(s.p0) * scs) >>> 8);
                s.p1 = sat32((64'(s.p1) * scs) >>> 8);
                s.p2 = sat32((64'(s.p2) * scs) >>> 8);
                s.deriv = sat32((64'(s.deriv) * sca) >>> 8);
            end
            stg_next[m+2] = s;
        end
    end

    // output register
    always_comb
    begin
        stg_next[NStg-1] = stg_reg[NStg-2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[NStg-2:0], in_ch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NStg; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    assign out_ch.data.new_x = stg_reg[NStg-1].p0;
    assign out_ch.data.new_y = stg_reg[NStg-1].p1;
    assign out_ch.data.new_z = stg_reg[NStg-1].p2;
    assign out_ch.data.dist_out = stg_reg[NStg-1].dst;
    assign out_ch.data.deriv_out = stg_reg[NStg-1].deriv;
    assign out_ch.data.color_out = stg_reg[NStg-1].color;

endmodule

// ----- sv/cbds_checker.sv -----
module cbds_assert (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cfg_ready
);
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input stalled with empty output");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("output dropped");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready) else $error("accept during stall");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready) else $error("config not ready");
endmodule

bind chessboard_box_distance_step_top cbds_assert u_cbds_assert (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cfg_ready(cfg_ch.ready)
);
